/* hdl/kst_pkg.sv */
// shared types and constants of the k smallest distinct values tracker
package kst_pkg;

  localparam int MAX_KEEP = 16;
  localparam int VAL_W = 32;
  localparam int CFG_W = 5;
  localparam int CNT_W = $clog2(MAX_KEEP + 1);

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_SHIFT
  } cell_op_t;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

  typedef enum logic {
    CMD_OFFER,
    CMD_END
  } cmd_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    cell_op_t                 op;
    logic signed [VAL_W-1:0]  offer;
    logic [CNT_W-1:0]         count;
    logic [CNT_W-1:0]         lim;
  } cell_ctrl_t;

endpackage

/* hdl/kst_ifs.sv */
// request and result channel interfaces of the tracker
interface kst_req_if import kst_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    cmd;
  logic signed [VAL_W-1:0] offered_value;

  modport source (output valid, output cmd, output offered_value, input ready);
  modport sink (input valid, input cmd, input offered_value, output ready);
endinterface

interface kst_res_if import kst_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] kept_value;
  logic                    last_of_run;
  logic                    set_empty;

  modport source (output valid, output kept_value, output last_of_run, output set_empty,
                  input ready);
  modport sink (input valid, input kept_value, input last_of_run, input set_empty,
                output ready);
endinterface

/* hdl/kst_cell.sv */
// one entry of the sorted chain: compare against the offer, shift right or left
module kst_cell import kst_pkg::*; (
  input  logic                    clk,
  input  cell_ctrl_t              ctrl,
  input  logic [CNT_W-1:0]        idx,
  input  logic signed [VAL_W-1:0] left_value,
  input  logic                    left_gt,
  input  logic signed [VAL_W-1:0] right_value,
  output logic signed [VAL_W-1:0] value,
  output logic                    gt,
  output logic                    hit
);

  logic valid;

  assign valid = idx < ctrl.count;
  assign hit   = valid && (value == ctrl.offer);
  assign gt    = valid && (value > ctrl.offer);

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      OP_HOLD: begin
      end
      OP_INSERT: begin
        // cells past the insert point take their left neighbor
        if (idx <= ctrl.lim) begin
          if (left_gt) begin
            value <= left_value;
          end else if (gt || idx == ctrl.lim) begin
            value <= ctrl.offer;
          end
        end
      end
      OP_SHIFT: begin
        value <= right_value;
      end
      default: begin
      end
    endcase
  end

endmodule

/* hdl/k_smallest_distinct_tracker.sv */
// top level: cell chain, held count, readout sequencer and result register
//
//  channel   dir   payload                                   transfer
//  req       in    cmd, offered_value                        valid & ready
//  res       out   kept_value, last_of_run, set_empty        valid & ready
//  cfg       in    cfg_wdata (keep_count)                    cfg_we
//
// on an offer all cells compare in parallel and shift in one step
// an end request reads out n held values (one empty-set result if none), one per cycle
//   unless res stalls, via the result register, cell 0 feeding it as the chain shifts left
// req.ready is low during readout; a stalled res holds the readout in place
// rst is synchronous: held count cleared, keep_count back to MAX_KEEP
module k_smallest_distinct_tracker import kst_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  kst_req_if.sink          req,
  kst_res_if.source        res
);

  logic [CFG_W-1:0]        keep_count;
  logic [CNT_W-1:0]        keep_eff;
  logic [CNT_W-1:0]        held_count;
  logic [CNT_W-1:0]        held_count_next;
  state_t                  state;
  state_t                  state_next;
  cell_ctrl_t              ctrl;

  logic signed [VAL_W-1:0] cell_value [MAX_KEEP];
  logic [MAX_KEEP-1:0]     cell_gt;
  logic [MAX_KEEP-1:0]     cell_hit;

  logic                    res_valid;
  logic signed [VAL_W-1:0] res_value;
  logic                    res_last;
  logic                    res_empty;
  logic                    slot_free;
  logic                    load;
  logic signed [VAL_W-1:0] load_value;
  logic                    load_last;
  logic                    load_empty;
  logic                    offer_acc;
  logic                    any_hit;
  logic                    any_gt;

  assign req.ready       = (state == ST_IDLE);
  assign res.valid       = res_valid;
  assign res.kept_value  = res_value;
  assign res.last_of_run = res_last;
  assign res.set_empty   = res_empty;

  assign slot_free = !res_valid || res.ready;
  assign offer_acc = req.valid && req.ready && (req.cmd == CMD_OFFER);
  assign any_hit   = |cell_hit;
  // entries are ascending, so any larger entry means the maximum is larger
  assign any_gt    = |cell_gt;

  always_comb begin
    if (keep_count == '0) begin
      keep_eff = CNT_W'(1);
    end else if (CNT_W'(keep_count) > CNT_W'(MAX_KEEP)) begin
      keep_eff = CNT_W'(MAX_KEEP);
    end else begin
      keep_eff = CNT_W'(keep_count);
    end
  end

  generate
    for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
      logic signed [VAL_W-1:0] lv;
      logic                    lg;
      logic signed [VAL_W-1:0] rv;
      if (i == 0) begin : g_first
        assign lv = '0;
        assign lg = 1'b0;
      end else begin : g_mid
        assign lv = cell_value[i-1];
        assign lg = cell_gt[i-1];
      end
      if (i == MAX_KEEP - 1) begin : g_last
        assign rv = '0;
      end else begin : g_inner
        assign rv = cell_value[i+1];
      end
      kst_cell u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .idx         (CNT_W'(i)),
        .left_value  (lv),
        .left_gt     (lg),
        .right_value (rv),
        .value       (cell_value[i]),
        .gt          (cell_gt[i]),
        .hit         (cell_hit[i])
      );
    end
  endgenerate

  always_comb begin
    state_next      = state;
    held_count_next = held_count;
    ctrl.op         = OP_HOLD;
    ctrl.offer      = req.offered_value;
    ctrl.count      = held_count;
    ctrl.lim        = held_count;
    load            = 1'b0;
    load_value      = '0;
    load_last       = 1'b1;
    load_empty      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (req.valid && req.cmd == CMD_END) begin
          state_next = ST_READ;
        end else if (offer_acc && !any_hit) begin
          if (held_count < keep_eff) begin
            ctrl.op         = OP_INSERT;
            held_count_next = held_count + CNT_W'(1);
          end else if (any_gt) begin
            // evict the maximum: the insert stops one entry short
            ctrl.op  = OP_INSERT;
            ctrl.lim = held_count - CNT_W'(1);
          end
        end
      end
      ST_READ: begin
        if (slot_free) begin
          load = 1'b1;
          if (held_count == '0) begin
            load_empty = 1'b1;
            state_next = ST_IDLE;
          end else begin
            load_value      = cell_value[0];
            load_last       = (held_count == CNT_W'(1));
            ctrl.op         = OP_SHIFT;
            held_count_next = held_count - CNT_W'(1);
            if (held_count == CNT_W'(1)) begin
              state_next = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      held_count <= '0;
      keep_count <= CFG_W'(MAX_KEEP);
      res_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      held_count <= held_count_next;
      if (cfg_we) begin
        keep_count <= cfg_wdata;
      end
      if (load) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_value <= load_value;
      res_last  <= load_last;
      res_empty <= load_empty;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    held_count <= CNT_W'(MAX_KEEP))
    else $error("held count beyond capacity");

  a_sorted: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cell_gt & ~(cell_gt << 1)))
    else $error("entries above the offer are not one contiguous run");

  a_dup_ignored: assert property (@(posedge clk) disable iff (rst)
    offer_acc && any_hit |=> $stable(held_count))
    else $error("duplicate offer changed the held count");

  a_last_ends_read: assert property (@(posedge clk) disable iff (rst)
    state == ST_READ && load && load_last |=> state == ST_IDLE && held_count == '0)
    else $error("readout did not finish on the last result");

  a_empty_alone: assert property (@(posedge clk) disable iff (rst)
    load && load_empty |-> held_count == '0 && load_last)
    else $error("empty result with values held");

endmodule
